[src/spsf_pkg.sv]
// Shared constants and types for the stereo ping-pong PWM sample feeder.
package spsf_pkg;

    // Buffer geometry: one memory row holds one stereo frame (left, right).
    localparam int FRAMES_PER_BUFFER = 1152;
    localparam int SLOTS_PER_BUFFER  = 2 * FRAMES_PER_BUFFER;
    localparam int STORE_ROWS        = 2 * FRAMES_PER_BUFFER;
    localparam int ROW_W             = $clog2(STORE_ROWS);
    localparam int POS_W             = (FRAMES_PER_BUFFER > 1) ? $clog2(FRAMES_PER_BUFFER) : 1;

    // Field widths fixed by the interface.
    localparam int DUTY_W  = 16;
    localparam int WIDX_W  = 12;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W = 32;

    // Duty scaling.
    localparam int SAMPLE_OFFSET  = 32768;
    localparam int SPAN_RESET_INT = 4000;
    localparam logic [DUTY_W-1:0] SPAN_RESET = DUTY_W'(SPAN_RESET_INT);
    localparam logic [DUTY_W-1:0] MID_DUTY   =
        DUTY_W'((SAMPLE_OFFSET * SPAN_RESET_INT) >> 16);

    // APB register map.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_SPAN = REG_IDX_W'(0);

    // Request kinds.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic [WIDX_W-1:0]          write_index;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       last_write;
    } req_beat_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  left_duty;
        logic [DUTY_W-1:0]  right_duty;
        logic               duty_valid;
        logic               refill_request;
        logic               playing_buffer;
        logic [COUNT_W-1:0] swap_count;
    } rsp_beat_t;

    typedef struct packed {
        logic              wr_left;
        logic              wr_right;
        logic [ROW_W-1:0]  wr_row;
        logic [DUTY_W-1:0] wr_data;
        logic              rd_en;
        logic [ROW_W-1:0]  rd_row;
    } mem_req_t;

    typedef struct packed {
        logic               refill;
        logic               playing;
        logic [COUNT_W-1:0] swaps;
    } play_status_t;

endpackage

[src/spsf_cfg_regs.sv]
// APB configuration register block: holds duty_span.
module spsf_cfg_regs
    import spsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [DUTY_W-1:0]  duty_span
);

    logic [DUTY_W-1:0]    span_reg;
    logic [DUTY_W-1:0]    span_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_strobe;

    assign reg_idx   = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_strobe = psel & penable & pwrite & pready;

    always_comb
    begin
        span_next = span_reg;
        if (wr_strobe && reg_idx == REG_DUTY_SPAN)
        begin
            span_next = pwdata[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= SPAN_RESET;
        end
        else
        begin
            span_reg <= span_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_DUTY_SPAN)
        begin
            prdata = PDATA_W'(span_reg);
        end
    end

    assign duty_span = span_reg;

endmodule

[src/spsf_duty_mem.sv]
// Duty store: left and right duty memories plus the post-reset clearing pass.
module spsf_duty_mem
    import spsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          mem_req,
    output logic [DUTY_W-1:0] rd_left,
    output logic [DUTY_W-1:0] rd_right,
    output logic              clr_busy
);

    logic [DUTY_W-1:0] left_mem  [STORE_ROWS];
    logic [DUTY_W-1:0] right_mem [STORE_ROWS];

    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ROW_W-1:0]  clr_row_reg;
    logic [ROW_W-1:0]  clr_row_next;
    logic [DUTY_W-1:0] rd_left_reg;
    logic [DUTY_W-1:0] rd_right_reg;

    logic              we_left;
    logic              we_right;
    logic [ROW_W-1:0]  wr_row;
    logic [DUTY_W-1:0] wr_data;

    // Clearing pass: one row per cycle, mid-scale into both halves.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_row_next  = clr_row_reg;
        if (clr_busy_reg)
        begin
            if (clr_row_reg == ROW_W'(STORE_ROWS - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_row_next = clr_row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_row_reg  <= clr_row_next;
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            we_left  = 1'b1;
            we_right = 1'b1;
            wr_row   = clr_row_reg;
            wr_data  = MID_DUTY;
        end
        else
        begin
            we_left  = mem_req.wr_left;
            we_right = mem_req.wr_right;
            wr_row   = mem_req.wr_row;
            wr_data  = mem_req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_left)
        begin
            left_mem[wr_row] <= wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_left_reg <= left_mem[mem_req.rd_row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_right)
        begin
            right_mem[wr_row] <= wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_right_reg <= right_mem[mem_req.rd_row];
        end
    end

    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;
    assign clr_busy = clr_busy_reg;

endmodule

[src/spsf_play_ctrl.sv]
// Playback state, duty scaling and memory request generation for one beat.
module spsf_play_ctrl
    import spsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  req_beat_t         beat,
    input  logic [DUTY_W-1:0] duty_span,
    output mem_req_t          mem_req,
    output play_status_t      status
);

    logic               active_reg;
    logic               active_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               refill_reg;
    logic               refill_next;
    logic [COUNT_W-1:0] swaps_reg;
    logic [COUNT_W-1:0] swaps_next;

    logic                  is_tick;
    logic                  in_range;
    logic [DUTY_W-1:0]     biased;
    logic [2*DUTY_W-1:0]   prod;
    logic [POS_W-1:0]      wr_pos;
    logic [ROW_W-1:0]      play_base;
    logic [ROW_W-1:0]      idle_base;

    assign is_tick  = (beat.req_type == REQ_TICK);
    assign in_range = (32'(beat.write_index) < SLOTS_PER_BUFFER);

    // s + 32768 on a 16-bit two's complement value is a sign-bit flip.
    assign biased = {~beat.sample_value[SAMPLE_W-1], beat.sample_value[SAMPLE_W-2:0]};
    assign prod   = biased * duty_span;

    assign wr_pos    = POS_W'(beat.write_index[WIDX_W-1:1]);
    assign play_base = active_reg ? ROW_W'(FRAMES_PER_BUFFER) : '0;
    assign idle_base = active_reg ? '0 : ROW_W'(FRAMES_PER_BUFFER);

    always_comb
    begin
        mem_req.wr_left  = step & ~is_tick & in_range & ~beat.write_index[0];
        mem_req.wr_right = step & ~is_tick & in_range &  beat.write_index[0];
        mem_req.wr_row   = idle_base + ROW_W'(wr_pos);
        mem_req.wr_data  = prod[2*DUTY_W-1:DUTY_W];
        mem_req.rd_en    = step & is_tick;
        mem_req.rd_row   = play_base + ROW_W'(pos_reg);
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        refill_next = refill_reg;
        swaps_next  = swaps_reg;
        if (step)
        begin
            if (is_tick)
            begin
                if (pos_reg == POS_W'(FRAMES_PER_BUFFER - 1))
                begin
                    // end of buffer: swap halves and ask for a refill
                    pos_next    = '0;
                    active_next = ~active_reg;
                    refill_next = 1'b1;
                    swaps_next  = swaps_reg + COUNT_W'(1);
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else if (beat.last_write)
            begin
                refill_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            refill_reg <= 1'b0;
            swaps_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            refill_reg <= refill_next;
            swaps_reg  <= swaps_next;
        end
    end

    assign status.refill  = refill_reg;
    assign status.playing = active_reg;
    assign status.swaps   = swaps_reg;

endmodule

[src/stereo_pingpong_pwm_sample_feeder.sv]
// Top level of the stereo ping-pong PWM sample feeder.
//
// Request channel (req_valid / req_stall / req_data): each beat is either a
// playback tick or a sample write into the idle buffer. Response channel
// (rsp_valid / rsp_stall / rsp_data): exactly one beat per request, in order.
// A tick response carries the left/right duties of the current frame with
// duty_valid set; a write response carries zero duties. Every response also
// shows refill_request, playing_buffer and swap_count after its request.
// A request moves from the input register into the memory read register and
// the result register, which load together. Throughput: one request per
// cycle while rsp_stall is low and no clearing pass runs. After reset a
// clearing pass writes mid-scale duty into all 2304 stereo rows (one row
// per cycle); req_stall stays high until it ends. APB writes are taken at
// any time. When rsp_stall is high the response holds and the pipeline
// fills: one more request is taken into the input register, then req_stall
// rises until the response is taken.
// duty_span is written over APB at byte address 0; it scales new samples
// only, stored duties keep their value.
module stereo_pingpong_pwm_sample_feeder
    import spsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_beat_t          req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_beat_t          rsp_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [DUTY_W-1:0] duty_span;
    mem_req_t          mem_req;
    play_status_t      status;
    logic [DUTY_W-1:0] rd_left;
    logic [DUTY_W-1:0] rd_right;
    logic              clr_busy;

    // input register
    logic      a_valid_reg;
    logic      a_valid_next;
    req_beat_t a_beat_reg;

    // result register; duties come from the memory read register
    logic b_valid_reg;
    logic b_valid_next;
    logic b_tick_reg;

    logic req_take;
    logic b_free;
    logic a_move;

    assign b_free    = ~b_valid_reg | ~rsp_stall;
    assign a_move    = a_valid_reg & b_free;
    assign req_stall = clr_busy | (a_valid_reg & ~b_free);
    assign req_take  = req_valid & ~req_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (req_take)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (b_free)
        begin
            b_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            a_beat_reg <= req_data;
        end
        if (a_move)
        begin
            b_tick_reg <= (a_beat_reg.req_type == REQ_TICK);
        end
    end

    spsf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .duty_span (duty_span)
    );

    // Playback state advances as a beat moves into the result register, so
    // the state registers always match the beat held there.
    spsf_play_ctrl u_play (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (a_move),
        .beat      (a_beat_reg),
        .duty_span (duty_span),
        .mem_req   (mem_req),
        .status    (status)
    );

    spsf_duty_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .mem_req  (mem_req),
        .rd_left  (rd_left),
        .rd_right (rd_right),
        .clr_busy (clr_busy)
    );

    assign rsp_valid = b_valid_reg;

    always_comb
    begin
        rsp_data.left_duty      = b_tick_reg ? rd_left  : '0;
        rsp_data.right_duty     = b_tick_reg ? rd_right : '0;
        rsp_data.duty_valid     = b_tick_reg;
        rsp_data.refill_request = status.refill;
        rsp_data.playing_buffer = status.playing;
        rsp_data.swap_count     = status.swaps;
    end

endmodule

[bench/tb_stereo_pingpong_pwm_sample_feeder.sv]
// Self-checking testbench for the stereo ping-pong PWM sample feeder.
`timescale 1ns / 1ps

import spsf_pkg::*;

// Duty predictor plus in-order response queue for the feeder.
class feeder_scoreboard;
    logic [DUTY_W-1:0]  duty_mem [2*SLOTS_PER_BUFFER];
    bit                 playing;
    int unsigned        frame;
    bit                 refill;
    logic [COUNT_W-1:0] swaps;
    logic [DUTY_W-1:0]  span;
    rsp_beat_t          expected_q[$];
    int                 errors;
    int                 ticks;

    function new();
        foreach (duty_mem[i])
            duty_mem[i] = DUTY_W'((32768 * 4000) >> 16);
        playing = 1'b0;
        frame   = 0;
        refill  = 1'b0;
        swaps   = '0;
        span    = 16'd4000;
        errors  = 0;
        ticks   = 0;
    endfunction

    function void set_span(logic [DUTY_W-1:0] value);
        span = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_request(req_beat_t r);
        rsp_beat_t   want;
        logic [31:0] prod;
        int unsigned slot;
        want = '0;
        if (r.req_type == REQ_WRITE)
        begin
            if (r.write_index < SLOTS_PER_BUFFER)
            begin
                // offset binary: flip the sign bit, then scale by the span
                prod = 32'({~r.sample_value[SAMPLE_W-1], r.sample_value[SAMPLE_W-2:0]})
                       * 32'(span);
                slot = (playing ? 0 : SLOTS_PER_BUFFER) + int'(r.write_index);
                duty_mem[slot] = prod[31:16];
            end
            if (r.last_write)
                refill = 1'b0;
        end
        else
        begin
            slot = (playing ? SLOTS_PER_BUFFER : 0) + 2 * frame;
            want.left_duty  = duty_mem[slot];
            want.right_duty = duty_mem[slot + 1];
            want.duty_valid = 1'b1;
            ticks++;
            frame++;
            if (frame >= FRAMES_PER_BUFFER)
            begin
                playing = ~playing;
                refill  = 1'b1;
                frame   = 0;
                swaps   = swaps + 1'b1;
            end
        end
        want.refill_request = refill;
        want.playing_buffer = playing;
        want.swap_count     = swaps;
        expected_q.push_back(want);
    endfunction

    function void check_response(rsp_beat_t got);
        rsp_beat_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("response beat with nothing outstanding: %h", got);
            return;
        end
        want = expected_q.pop_front();
        if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
            got.duty_valid !== want.duty_valid ||
            got.refill_request !== want.refill_request ||
            got.playing_buffer !== want.playing_buffer ||
            got.swap_count !== want.swap_count)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch exp: L=%0d R=%0d dv=%b rq=%b pb=%b sw=%0d",
                         want.left_duty, want.right_duty, want.duty_valid,
                         want.refill_request, want.playing_buffer, want.swap_count);
                $display("         got: L=%0d R=%0d dv=%b rq=%b pb=%b sw=%0d",
                         got.left_duty, got.right_duty, got.duty_valid,
                         got.refill_request, got.playing_buffer, got.swap_count);
            end
        end
    endfunction
endclass

module tb_stereo_pingpong_pwm_sample_feeder;

    // Cycles with no beat on either channel before the run is declared hung.
    // The clearing pass after reset alone holds req_stall until all 2304 rows are written.
    localparam int QUIET_LIMIT = 12000;
    // Random beats per span setting; the last phase runs on until the
    // playing buffer has swapped and the start of the refill was played.
    localparam int PHASE_BEATS = 270;
    localparam int PHASES      = 5;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    req_beat_t          req_data;
    logic               rsp_valid;
    logic               rsp_stall;
    rsp_beat_t          rsp_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    feeder_scoreboard sb = new();
    bit               idling_on;
    int               quiet_cycles = 0;

    stereo_pingpong_pwm_sample_feeder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // Response side back-pressure: random bursts of stalled cycles,
    // switched off for the final phase so the tail runs at full rate.
    initial
    begin
        int burst;
        rsp_stall = 1'b0;
        burst     = 0;
        forever
        begin
            @(negedge clk);
            if (burst > 0 && idling_on)
            begin
                rsp_stall = 1'b1;
                burst--;
            end
            else
            begin
                rsp_stall = 1'b0;
                burst     = 0;
                if (idling_on && $urandom_range(0, 6) == 0)
                    burst = $urandom_range(1, 6);
            end
        end
    end

    // Beat monitor: both channels are sampled at the rising edge, the
    // request side first so the prediction is queued before any check.
    // Also the watchdog: counts edges with no beat on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req_data);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp_data);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic req_beat_t make_beat(logic kind, int idx, int sample, logic last);
        req_beat_t r;
        r.req_type     = kind;
        r.write_index  = WIDX_W'(idx);
        r.sample_value = SAMPLE_W'(sample);
        r.last_write   = last;
        return r;
    endfunction

    // Mostly ticks so the playing buffer wraps within the run. Writes lean
    // toward the low frames, which get played right after the swap; some go
    // anywhere in the buffer and some past its end (dropped by the block).
    function automatic req_beat_t random_beat();
        req_beat_t r;
        int        pick;
        r.req_type   = ($urandom_range(0, 99) < 88) ? REQ_TICK : REQ_WRITE;
        r.last_write = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 19);
        if (pick < 12)
            r.write_index = WIDX_W'($urandom_range(0, 511));
        else if (pick < 17)
            r.write_index = WIDX_W'($urandom_range(0, SLOTS_PER_BUFFER - 1));
        else
            r.write_index = WIDX_W'($urandom_range(SLOTS_PER_BUFFER, 4095));
        pick = $urandom_range(0, 7);
        if (pick == 0)
            r.sample_value = 16'sh8000;
        else if (pick == 1)
            r.sample_value = 16'sh7FFF;
        else
            r.sample_value = SAMPLE_W'($urandom);
        return r;
    endfunction

    // Present one request beat (called at a falling edge, returns at the
    // falling edge after the beat was taken). valid stays high between
    // back-to-back beats; an optional gap drops it first.
    task automatic send_request(req_beat_t r);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap       = $urandom_range(1, 6);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_data  = r;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // duty_span update over APB, only once every response is back.
    task automatic program_span(logic [DUTY_W-1:0] value);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({REG_DUTY_SPAN, 2'b00});
        pwdata  = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_span(value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial
    begin
        logic [DUTY_W-1:0] span_now;
        int                beats;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idling_on    = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats at the reset span of 4000.
        // Fresh buffer reads back mid-scale; tick ignores its write fields.
        send_request(make_beat(REQ_TICK, 4095, -32768, 1'b1));
        // Sample extremes land in the idle buffer: full negative -> 0,
        // full positive -> span-1, zero and +/-1 around mid-scale.
        send_request(make_beat(REQ_WRITE, 0, -32768, 1'b0));
        send_request(make_beat(REQ_WRITE, 1, 32767, 1'b0));
        send_request(make_beat(REQ_WRITE, SLOTS_PER_BUFFER - 1, 0, 1'b0));
        send_request(make_beat(REQ_WRITE, SLOTS_PER_BUFFER - 2, -1, 1'b0));
        send_request(make_beat(REQ_WRITE, 2, 1, 1'b0));
        // Slots past the buffer end store nothing; last_write still clears
        // the request, even when no refill is pending.
        send_request(make_beat(REQ_WRITE, SLOTS_PER_BUFFER, 12345, 1'b0));
        send_request(make_beat(REQ_WRITE, 4095, -32768, 1'b1));
        // Write with no refill pending is stored anyway.
        send_request(make_beat(REQ_WRITE, 3, 16'h5A5A, 1'b1));
        send_request(make_beat(REQ_TICK, 0, 0, 1'b0));
        send_request(make_beat(REQ_TICK, 2048, 32767, 1'b0));
        send_request(make_beat(REQ_TICK, 1365, -21846, 1'b1));
        req_valid = 1'b0;

        // Random phases, each with its own span: both ends of the range,
        // the degenerate zero span, then random values.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       span_now = 16'hFFFF;
                1:       span_now = 16'd1;
                2:       span_now = 16'd0;
                default: span_now = DUTY_W'($urandom_range(2, 65534));
            endcase
            if (phase == PHASES - 1)
                idling_on = 1'b0;
            program_span(span_now);
            beats = 0;
            while (beats < PHASE_BEATS ||
                   (phase == PHASES - 1 && sb.ticks < FRAMES_PER_BUFFER + 64))
            begin
                send_request(random_beat());
                beats++;
            end
            req_valid = 1'b0;
        end

        // Drain, then keep the clock running to catch any stray response beat.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
